// File: hdl/ptb_pkg.sv
package ptb_pkg;

  // Fixed block size in bytes and field widths of the item ports
  localparam int BLOCK_BYTES = 16384;
  localparam int OFF_W       = 20;
  localparam int OP_W        = 3;
  localparam int IDX_OUT_W   = 6;
  localparam int LEN_W       = 15;
  localparam int BCNT_W      = 7;
  localparam int PLEN_W      = 21;
  localparam int TOUT_W      = 8;
  localparam int SEC_W       = 32;

  // Block number taken from a byte offset
  localparam int BNUM_W = $clog2(((2 ** OFF_W) - 1) / BLOCK_BYTES + 1);

  // Per-block status codes
  localparam logic [1:0] BLK_FREE    = 2'd0;
  localparam logic [1:0] BLK_PENDING = 2'd1;
  localparam logic [1:0] BLK_FULL    = 2'd2;

  // Store word: status on top, time stamp below
  localparam int ENTRY_W = 2 + SEC_W;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
  localparam logic [1:0] REG_PIECE_LENGTH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST = 3'd0,
    OP_RECEIVE = 3'd1,
    OP_TICK    = 3'd2,
    OP_SWEEP   = 3'd3,
    OP_VERIFY  = 3'd4
  } ptb_op_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ptb_state_e;

endpackage

// File: hdl/ptb_ram.sv
module ptb_ram #(
  parameter int Width = 34,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/piece_block_tracker_core.sv
// Channel | Handshake                  | Word
// --------+----------------------------+-----------------------------------------------
// config  | psel/penable/pwrite, APB   | block_count, piece_length, timeout_seconds
// in      | in_valid_i / in_ready_o    | operation, byte_offset, hash_ok
// out     | out_valid_o / out_ready_i  | granted .. piece_complete (seven fields)
//
// Each word walks the active blocks through the one read port of the block store, one
// block per cycle. A failed verify clears all MAX_BLOCKS entries instead. After reset
// the same clear pass runs with in_ready_o low. A result waits in the output register
// while the next word is accepted; a stalled out side holds the result after it in
// S_FINISH, and no further word is accepted until that result loads.
module piece_block_tracker_core #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptb_pkg::OP_W-1:0]   operation_i,
  input  logic [ptb_pkg::OFF_W-1:0]  byte_offset_i,
  input  logic                       hash_ok_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       granted_o,
  output logic [ptb_pkg::IDX_OUT_W-1:0] blk_idx_o,
  output logic [ptb_pkg::LEN_W-1:0]  block_length_o,
  output logic                       accepted_o,
  output logic                       out_of_range_o,
  output logic                       all_full_o,
  output logic                       piece_complete_o
);

  import ptb_pkg::*;

  localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam int CmpW = (BNUM_W > CntW) ? BNUM_W : CntW;

  // Configuration registers
  logic [BCNT_W-1:0] bcount_q;
  logic [PLEN_W-1:0] plen_q;
  logic [TOUT_W-1:0] tout_q;
  logic              cfg_we;

  // Sequencer and item state
  ptb_state_e        state_q, state_d;
  ptb_op_e           op_q;
  logic [BNUM_W-1:0] blk_q;
  logic              oor_q;
  logic              grant_q;
  logic [IdxW-1:0]   gidx_q;
  logic              acc_q;
  logic              allf_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              rd_go_q;
  logic              ev_vld_q;
  logic [IdxW-1:0]   ev_idx_q;
  logic [IdxW-1:0]   clr_idx_q;
  logic              clr_item_q;
  logic [SEC_W-1:0]  sec_q;
  logic              cmp_q;

  // Block store port
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Combinational helpers
  logic [CntW-1:0]    n_act;
  logic [IdxW-1:0]    last_idx;
  logic [BNUM_W-1:0]  in_blk;
  logic               in_accept;
  logic               out_load;
  logic               clr_last;
  logic               scan_last;
  logic [1:0]         rd_st;
  logic [SEC_W-1:0]   rd_stamp;
  logic [SEC_W-1:0]   age;
  logic               stale;
  logic [1:0]         post_st;
  logic               ev_grant;
  logic               ev_accept;
  logic [PLEN_W-1:0]  len_rem;
  logic [PLEN_W-1:0]  len_full;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= BCNT_W'(1);
      plen_q   <= PLEN_W'(16384);
      tout_q   <= TOUT_W'(5);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BLOCK_COUNT:  bcount_q <= pwdata[BCNT_W-1:0];
        REG_PIECE_LENGTH: plen_q   <= pwdata[PLEN_W-1:0];
        REG_TIMEOUT:      tout_q   <= pwdata[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BLOCK_COUNT:  prdata = 32'(bcount_q);
      REG_PIECE_LENGTH: prdata = 32'(plen_q);
      REG_TIMEOUT:      prdata = 32'(tout_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- derived counts ----------------
  always_comb begin
    if (bcount_q == '0) begin
      n_act = CntW'(1);
    end else if (int'(bcount_q) > MAX_BLOCKS) begin
      n_act = CntW'(MAX_BLOCKS);
    end else begin
      n_act = CntW'(bcount_q);
    end
  end

  assign last_idx  = IdxW'(n_act - CntW'(1));
  assign in_blk    = BNUM_W'(byte_offset_i / BLOCK_BYTES);
  assign in_accept = in_valid_i & in_ready_o;
  assign out_load  = (state_q == S_FINISH) & (~out_valid_o | out_ready_i);
  assign clr_last  = (clr_idx_q == IdxW'(MAX_BLOCKS - 1));
  assign scan_last = ev_vld_q & (ev_idx_q == last_idx);

  // ---------------- shared evaluation unit ----------------
  assign rd_st    = ram_rdata[ENTRY_W-1 -: 2];
  assign rd_stamp = ram_rdata[SEC_W-1:0];
  assign age      = sec_q - rd_stamp;
  assign stale    = age > SEC_W'(tout_q);

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = clr_item_q ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (operation_i == OP_VERIFY && !cmp_q && !hash_ok_i) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ev_idx_q;
    ram_wdata  = {BLK_FREE, SEC_W'(0)};
    ram_raddr  = rd_idx_q;
    post_st    = rd_st;
    ev_grant   = 1'b0;
    ev_accept  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_SCAN: begin
        if (ev_vld_q) begin
          unique case (op_q)
            OP_REQUEST: begin
              if (!cmp_q && !grant_q && rd_st == BLK_FREE) begin
                ev_grant  = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = {BLK_PENDING, sec_q};
                post_st   = BLK_PENDING;
              end
            end
            OP_RECEIVE: begin
              if (!oor_q && !cmp_q && rd_st != BLK_FULL &&
                  CmpW'(ev_idx_q) == CmpW'(blk_q)) begin
                ev_accept = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = {BLK_FULL, rd_stamp};
                post_st   = BLK_FULL;
              end
            end
            OP_SWEEP: begin
              if (rd_st == BLK_PENDING && stale) begin
                ram_we    = 1'b1;
                ram_wdata = {BLK_FREE, SEC_W'(0)};
                post_st   = BLK_FREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  // ---------------- sequencer and item registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_idx_q  <= '0;
      clr_item_q <= 1'b0;
      rd_go_q    <= 1'b0;
      ev_vld_q   <= 1'b0;
      sec_q      <= '0;
      cmp_q      <= 1'b0;
      grant_q    <= 1'b0;
      acc_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      ev_vld_q <= (state_q == S_SCAN) & rd_go_q;

      if (state_q == S_CLEAR) begin
        clr_idx_q <= clr_last ? '0 : clr_idx_q + IdxW'(1);
      end

      if (in_accept) begin
        grant_q    <= 1'b0;
        acc_q      <= 1'b0;
        rd_go_q    <= 1'b1;
        clr_item_q <= 1'b1;
        if (operation_i == OP_TICK) begin
          sec_q <= sec_q + SEC_W'(1);
        end
        if (operation_i == OP_VERIFY && !cmp_q && hash_ok_i) begin
          cmp_q <= 1'b1;
        end
      end else if (state_q == S_SCAN) begin
        if (rd_go_q && rd_idx_q == last_idx) begin
          rd_go_q <= 1'b0;
        end
        if (ev_grant) begin
          grant_q <= 1'b1;
        end
        if (ev_accept) begin
          acc_q <= 1'b1;
        end
      end
    end
  end

  // Payload of the item in flight
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= ptb_op_e'(operation_i);
      blk_q    <= in_blk;
      oor_q    <= (CmpW'(in_blk) >= CmpW'(n_act));
      rd_idx_q <= '0;
      // a failed verify frees every block, so the piece cannot be full
      allf_q   <= !(operation_i == OP_VERIFY && !cmp_q && !hash_ok_i);
    end else if (state_q == S_SCAN) begin
      if (rd_go_q && rd_idx_q != last_idx) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      if (ev_vld_q && post_st != BLK_FULL) begin
        allf_q <= 1'b0;
      end
      if (ev_grant) begin
        gidx_q <= ev_idx_q;
      end
    end
    ev_idx_q <= rd_idx_q;
  end

  // ---------------- block length of the granted block ----------------
  assign len_rem = PLEN_W'(plen_q % BLOCK_BYTES);

  always_comb begin
    if (n_act == CntW'(1)) begin
      len_full = (plen_q > PLEN_W'(BLOCK_BYTES)) ? PLEN_W'(BLOCK_BYTES) : plen_q;
    end else if (gidx_q == last_idx && len_rem != '0) begin
      len_full = len_rem;
    end else begin
      len_full = PLEN_W'(BLOCK_BYTES);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_o        <= grant_q;
      accepted_o       <= acc_q;
      out_of_range_o   <= (op_q == OP_RECEIVE) & oor_q;
      all_full_o       <= allf_q;
      piece_complete_o <= cmp_q;
      if (grant_q) begin
        blk_idx_o      <= IDX_OUT_W'(gidx_q);
        block_length_o <= len_full[LEN_W-1:0];
      end else begin
        block_length_o <= '0;
        if (op_q == OP_RECEIVE && !oor_q) begin
          blk_idx_o <= IDX_OUT_W'(blk_q);
        end else begin
          blk_idx_o <= '0;
        end
      end
    end
  end

  // ---------------- block store ----------------
  ptb_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_BLOCKS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
